FILE: design/bsm_pkg.sv
// Shared constants and types for the radix-2 Booth sequential multiplier.
// No dependencies; imported by every module of the block.
package bsm_pkg;

    localparam int WIDTH      = 16;              // operand width, 2..32
    localparam int ACC_W      = WIDTH + 1;       // one guard bit for the most negative operand
    localparam int OPND_W     = 16;              // width of each operand field on the port
    localparam int PROD_W     = 32;              // width of the product field on the port
    localparam int FULL_W     = ACC_W + WIDTH;   // accumulator joined to the multiplier register
    localparam int IN_DATA_W  = ((2 * OPND_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((PROD_W + 7) / 8) * 8;
    localparam int CNT_W      = $clog2(WIDTH);

    typedef struct packed {
        logic load;     // take new operands, clear the partial product
        logic step;     // one Booth add/subtract and arithmetic shift
        logic store;    // copy the finished product into the output register
    } bsm_cmd_t;

endpackage

FILE: design/bsm_ctrl.sv
// Controller for the Booth multiplier: sequences load, steps and store.
// Depends on bsm_pkg; drives bsm_datapath through bsm_cmd_t.
module bsm_ctrl
    import bsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output bsm_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load  = in_valid && in_ready;
        cmd.step  = (state_reg == ST_RUN);
        // output register is free if empty or its beat goes out this cycle
        cmd.store = (state_reg == ST_HOLD) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (cmd.store)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.store)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/bsm_datapath.sv
// Datapath for the Booth multiplier: accumulator, multiplier shift register,
// extra low bit, held multiplicand and output register. Depends on bsm_pkg.
module bsm_datapath
    import bsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  bsm_cmd_t          cmd,
    input  logic [OPND_W-1:0] multiplicand,
    input  logic [OPND_W-1:0] multiplier,
    output logic [PROD_W-1:0] product
);

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [WIDTH-1:0]  q_reg, q_next;
    logic              q_extra_reg, q_extra_next;
    logic [ACC_W-1:0]  mcand_reg, mcand_next;
    logic [PROD_W-1:0] product_reg;

    logic [WIDTH+OPND_W-1:0]  mcand_wide;
    logic [WIDTH+OPND_W-1:0]  mplier_wide;
    logic [WIDTH-1:0]         mcand_op;
    logic [ACC_W-1:0]         acc_sum;
    logic [FULL_W-1:0]        full_prod;
    logic [FULL_W+PROD_W-1:0] full_wide;

    // operands are taken as their low WIDTH bits
    assign mcand_wide  = {{WIDTH{1'b0}}, multiplicand};
    assign mplier_wide = {{WIDTH{1'b0}}, multiplier};
    assign mcand_op    = mcand_wide[WIDTH-1:0];

    always_comb
    begin
        unique case ({q_reg[0], q_extra_reg})
            2'b01:   acc_sum = acc_reg + mcand_reg;
            2'b10:   acc_sum = acc_reg - mcand_reg;
            default: acc_sum = acc_reg;
        endcase
    end

    always_comb
    begin
        acc_next     = acc_reg;
        q_next       = q_reg;
        q_extra_next = q_extra_reg;
        mcand_next   = mcand_reg;
        priority if (cmd.load)
        begin
            acc_next     = '0;
            q_next       = mplier_wide[WIDTH-1:0];
            q_extra_next = 1'b0;
            mcand_next   = {mcand_op[WIDTH-1], mcand_op};
        end
        else if (cmd.step)
        begin
            // arithmetic shift right of {acc, q, extra} as one word
            acc_next     = {acc_sum[ACC_W-1], acc_sum[ACC_W-1:1]};
            q_next       = {acc_sum[0], q_reg[WIDTH-1:1]};
            q_extra_next = q_reg[0];
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    assign full_prod = {acc_reg, q_reg};
    assign full_wide = {{PROD_W{1'b0}}, full_prod};
    assign product   = product_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            q_reg       <= '0;
            q_extra_reg <= 1'b0;
            mcand_reg   <= '0;
        end
        else
        begin
            acc_reg     <= acc_next;
            q_reg       <= q_next;
            q_extra_reg <= q_extra_next;
            mcand_reg   <= mcand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            product_reg <= full_wide[PROD_W-1:0];
        end
    end

endmodule

FILE: design/booth_signed_multiplier.sv
// Channel   | dir | signals                    | tdata fields (low bit up)
// s_axis    | in  | tvalid, tready, tdata[31:0] | multiplicand[15:0], multiplier[31:16]
// m_axis    | out | tvalid, tready, tdata[31:0] | product[31:0]
//
// The accept edge loads the operands; the run state then performs 16 Booth
// add/subtract-and-shift steps through the single 17-bit adder, and the hold state
// stores into the output register. No new beat is taken until that store.
// A finished product waits in the output register while the next beat is taken;
// if that register is still full when the next product is done, the core holds.
// rst_n is asynchronous, active low; clears control, accumulator and counters.
// Top level; depends on bsm_pkg, bsm_ctrl, bsm_datapath.
module booth_signed_multiplier
    import bsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // multiplicand, multiplier
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // product
);

    bsm_cmd_t          cmd;
    logic [PROD_W-1:0] product;

    bsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    bsm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .multiplicand (s_axis_tdata[OPND_W-1:0]),
        .multiplier   (s_axis_tdata[2*OPND_W-1:OPND_W]),
        .product      (product)
    );

    assign m_axis_tdata = OUT_DATA_W'(product);

endmodule

FILE: design/bsm_checker.sv
// Port-level checks for booth_signed_multiplier, attached by bind.
// Depends on bsm_pkg.
module bsm_checker
    import bsm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic in_beat;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    // stalled result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_axis_tready)
        else $error("input taken while a product is in progress");

    // still busy through the last Booth step
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |-> ##17 !s_axis_tready)
        else $error("input ready before all steps were done");

    // a new result only appears at the end of a busy period
    a_result_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result beat without a product in progress");

endmodule

bind booth_signed_multiplier bsm_checker u_bsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/tb_booth_signed_multiplier.sv
// Self-checking testbench for booth_signed_multiplier: streams signed operand pairs,
// predicts each product with a bit-level Booth model and checks every output beat in order.
// Depends on bsm_pkg and the booth_signed_multiplier RTL.
module tb_booth_signed_multiplier;
    import bsm_pkg::*;

    localparam int TOTAL_BEATS = 950;
    localparam int TAIL_BEATS  = 120;      // final stretch with no idling on either side
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYC  = 40;

    typedef struct {
        logic [OPND_W-1:0] mcand;
        logic [OPND_W-1:0] mplier;
        int                gap;            // idle cycles before this beat is offered
        bit                drain_first;    // hold off until every product has come back
    } operand_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;    // multiplicand[15:0], multiplier[31:16]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;          // product[31:0]

    operand_beat_t         operand_q[$];
    logic [PROD_W-1:0]     product_q[$];

    int                    err_cnt = 0;
    int                    in_cnt = 0;
    int                    cyc_cnt = 0;
    logic                  drained = 1'b1;

    // driver state
    int                    gap_left = 0;
    bit                    gap_loaded = 1'b0;
    bit                    in_fire;
    logic                  nxt_valid;
    logic [IN_DATA_W-1:0]  nxt_data;

    // receiver state
    int                    stall_left = 0;
    int                    run_left = 0;
    logic [PROD_W-1:0]     want;

    booth_signed_multiplier uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Radix-2 Booth: pair {q0, q-1} = 01 adds, 10 subtracts, then a joint arithmetic shift.
    function automatic logic [PROD_W-1:0] booth_product(input logic [OPND_W-1:0] mcand,
                                                        input logic [OPND_W-1:0] mplier);
        logic [WIDTH-1:0]  m_w;
        logic [ACC_W-1:0]  m_ext;
        logic [ACC_W-1:0]  acc;
        logic [WIDTH-1:0]  q;
        logic              q_extra;
        logic [FULL_W-1:0] joined;
        m_w     = WIDTH'(mcand);
        m_ext   = {m_w[WIDTH-1], m_w};
        acc     = '0;
        q       = WIDTH'(mplier);
        q_extra = 1'b0;
        for (int i = 0; i < WIDTH; i++)
        begin
            case ({q[0], q_extra})
                2'b01:   acc = acc + m_ext;
                2'b10:   acc = acc - m_ext;
                default: ;
            endcase
            q_extra = q[0];
            q       = {acc[0], q[WIDTH-1:1]};
            acc     = {acc[ACC_W-1], acc[ACC_W-1:1]};
        end
        joined = {acc, q};
        return PROD_W'(joined);
    endfunction

    function automatic logic [OPND_W-1:0] pick_operand();
        logic [OPND_W-1:0] corners [8];
        corners = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
                    16'h8000, 16'h8001, 16'h5555, 16'hAAAA};
        case ($urandom_range(0, 7))
            0:       return corners[$urandom_range(0, 7)];
            1:       return OPND_W'($urandom_range(0, 31) - 16);
            default: return OPND_W'($urandom);
        endcase
    endfunction

    task automatic queue_beat(input logic [OPND_W-1:0] mcand, input logic [OPND_W-1:0] mplier,
                              input int gap, input bit drain_first);
        operand_beat_t b;
        b.mcand       = mcand;
        b.mplier      = mplier;
        b.gap         = gap;
        b.drain_first = drain_first;
        operand_q.push_back(b);
    endtask

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0d: %s", cyc_cnt, what);
        err_cnt++;
    endtask

    // Driver: offers the head of operand_q, honoring its gap and drain request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire = s_axis_tvalid && s_axis_tready;
            if (in_fire)
            begin
                operand_q.delete(0);
                gap_loaded = 1'b0;
            end
            nxt_valid = s_axis_tvalid;
            nxt_data  = s_axis_tdata;
            if (!s_axis_tvalid || in_fire)
            begin
                nxt_valid = 1'b0;
                nxt_data  = IN_DATA_W'($urandom);
                if (!gap_loaded && operand_q.size() > 0)
                begin
                    gap_left   = operand_q[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0)
                    gap_left--;
                else if (operand_q.size() > 0)
                begin
                    // drained is registered; a beat taken this edge is not yet counted there
                    if (!(operand_q[0].drain_first && (!drained || in_fire)))
                    begin
                        nxt_valid = 1'b1;
                        nxt_data  = {operand_q[0].mplier, operand_q[0].mcand};
                    end
                end
            end
            s_axis_tvalid <= nxt_valid;
            s_axis_tdata  <= nxt_data;
        end
    end

    // Monitor: predicts on every accepted operand beat, checks every product beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                product_q.push_back(booth_product(s_axis_tdata[OPND_W-1:0],
                                                  s_axis_tdata[2*OPND_W-1:OPND_W]));
                in_cnt++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (product_q.size() == 0)
                    flag_mismatch($sformatf("product %h with nothing pending", m_axis_tdata));
                else
                begin
                    want = product_q.pop_front();
                    if (m_axis_tdata[PROD_W-1:0] !== want)
                        flag_mismatch($sformatf("product got %h want %h",
                                                m_axis_tdata[PROD_W-1:0], want));
                end
            end
            drained <= (product_q.size() == 0);

            // sink backpressure: stall bursts, short runs and long calm stretches
            if (stall_left == 0 && run_left == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    run_left = $urandom_range(50, 300);
                else if ($urandom_range(0, 1) == 0)
                    stall_left = $urandom_range(1, 19);
                else
                    run_left = $urandom_range(1, 10);
            end
            if (in_cnt >= TOTAL_BEATS - TAIL_BEATS)
                m_axis_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                run_left--;
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cyc_cnt++;
        if (cyc_cnt > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        bit calm;
        int gap;
        // directed: extremes, most negative operands, dense add/subtract patterns
        queue_beat(16'h0000, 16'h0000, 0, 1'b0);
        queue_beat(16'h7FFF, 16'h7FFF, 0, 1'b0);
        queue_beat(16'h8000, 16'h8000, 0, 1'b0);
        queue_beat(16'h8000, 16'h7FFF, 2, 1'b0);
        queue_beat(16'h7FFF, 16'h8000, 0, 1'b0);
        queue_beat(16'hFFFF, 16'hFFFF, 0, 1'b0);
        queue_beat(16'h0001, 16'hFFFF, 5, 1'b0);
        queue_beat(16'h8000, 16'h0001, 0, 1'b0);
        queue_beat(16'h0001, 16'h8000, 0, 1'b0);
        queue_beat(16'h0000, 16'h8000, 1, 1'b0);
        queue_beat(16'h8000, 16'h0000, 0, 1'b0);
        queue_beat(16'h5555, 16'hAAAA, 0, 1'b0);
        queue_beat(16'hAAAA, 16'h5555, 0, 1'b0);
        queue_beat(16'hAAAA, 16'hAAAA, 3, 1'b0);
        queue_beat(16'h5555, 16'h5555, 0, 1'b0);
        queue_beat(16'hFFFF, 16'h8001, 0, 1'b0);
        queue_beat(16'h8001, 16'h8001, 0, 1'b0);
        queue_beat(16'h3039, 16'hFEBF, 0, 1'b0);
        queue_beat(16'h7FFF, 16'h0001, 0, 1'b0);
        queue_beat(16'h0F0F, 16'hF0F0, 0, 1'b0);
        calm = 1'b0;
        for (int i = operand_q.size(); i < TOTAL_BEATS; i++)
        begin
            if (i % 40 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (i >= TOTAL_BEATS - TAIL_BEATS || calm)
                gap = 0;
            else
                gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 19) : 0;
            queue_beat(pick_operand(), pick_operand(), gap,
                       (i == 20 || i == 400 || i == 700));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (in_cnt < TOTAL_BEATS || product_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
        if (product_q.size() != 0)
            flag_mismatch($sformatf("%0d products never arrived", product_q.size()));
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
